FILE: rtl/ccw_pkg.sv
`timescale 1ns / 1ps

package ccw_pkg;

    // Default build-time dimensions.
    localparam int DEF_WINDOW     = 5;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int COORD_W    = 11;
    localparam int INDEX_W    = 5;
    localparam int CENSUS_W   = 24;
    localparam int OUT_DATA_W = 56;

    // Register reset values and the smallest frame dimension.
    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam int               MIN_DIM            = 3;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

FILE: rtl/complete_census_window_top.sv
`timescale 1ns / 1ps
// An accepted pixel is registered in stage 1, then shifted into the window as the sequencer
// starts, emitting WINDOW*WINDOW census words per pixel inside the frame, one word per cycle
// while the output is ready, via the output register; the next pixel waits in stage 1.
// Pixels in the first WINDOW-1 rows or columns pass at one per cycle when the sequencer is idle.
// Reset (asynchronous, active low) clears the position counters and pipeline, and loads the
// registers with 640 and 480. The line memory is not cleared.

module complete_census_window_top #(
    parameter int WINDOW     = ccw_pkg::DEF_WINDOW,
    parameter int MAX_WIDTH  = ccw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ccw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ccw_pkg::cfg_index_t          cfg_addr,
    input  logic [ccw_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         cfg_we,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ccw_pkg::PIX_W-1:0]    s_tdata,   // [7:0] pixel
    input  logic                         s_tuser,   // [0] frame_start
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [10:0] centre_col, [21:11] centre_row, [26:22] centre_index,
    // [50:27] census_bits, [55:51] zero
    output logic [ccw_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                         m_tlast    // last
);

    import ccw_pkg::*;

    localparam int WIN_LEN = WINDOW * WINDOW;
    localparam int HALF    = WINDOW / 2;
    localparam int LINES   = WINDOW - 1;
    localparam int LW      = PIX_W * LINES;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int DW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int IW      = $clog2(WIN_LEN);
    localparam int NB      = WIN_LEN - 1;
    localparam int CB      = (NB > CENSUS_W) ? NB : CENSUS_W;
    localparam int PAD_W   = OUT_DATA_W - 2 * COORD_W - INDEX_W - CENSUS_W;

    // Configuration registers and the clamped frame dimensions.
    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [DW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        priority if (32'(line_width_reg) < MIN_DIM)
            w_eff = DW'(MIN_DIM);
        else if (32'(line_width_reg) > MAX_WIDTH)
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(line_width_reg);

        priority if (32'(frame_height_reg) < MIN_DIM)
            h_eff = HW'(MIN_DIM);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    // Pipeline and sequencer state.
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [RW-1:0]      s1_row_reg;
    logic               s1_emit_reg;
    logic               fwd_reg;
    logic [LW-1:0]      fwd_data_reg;
    logic [PIX_W-1:0]   win_reg [WIN_LEN];
    logic               busy_reg;
    logic [IW-1:0]      idx_reg;
    logic [COORD_W-1:0] seq_col_reg;
    logic [COORD_W-1:0] seq_row_reg;
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [CENSUS_W-1:0] out_census_reg;
    logic               out_last_reg;

    logic               in_accept;
    logic               s1_fire;
    logic               seq_adv;
    logic               seq_last;
    logic [CW-1:0]      col_in;
    logic [RW-1:0]      row_in;
    logic [CW-1:0]      c_cur;
    logic [RW-1:0]      r_cur;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_next;
    logic               emit_cur;
    logic               col_wrap;
    logic [LW-1:0]      ram_rdata;
    logic [LW-1:0]      line_word;
    logic [LW-1:0]      ram_wdata;
    logic [PIX_W-1:0]   column [WINDOW];
    logic [PIX_W-1:0]   ref_px;
    logic [WIN_LEN-1:0] lt;
    logic [NB-1:0]      census_vec;
    logic [CB-1:0]      census_ext;

    assign seq_last = (idx_reg == IW'(WIN_LEN - 1));
    assign seq_adv  = busy_reg && (!out_valid_reg || m_tready);
    assign s1_fire  = s1_valid_reg && (!busy_reg || (seq_adv && seq_last));
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_accept = s_tvalid && s_tready;

    // Raster position of the incoming pixel and of the one after it.
    always_comb
    begin
        col_in   = s_tuser ? '0 : col_reg;
        row_in   = s_tuser ? '0 : row_reg;
        c_cur    = (32'(col_in) >= 32'(w_eff)) ? '0 : col_in;
        r_cur    = (32'(row_in) >= 32'(h_eff)) ? '0 : row_in;
        emit_cur = (32'(c_cur) >= LINES) && (32'(r_cur) >= LINES);
        col_wrap = (32'(c_cur) + 32'd1) >= 32'(w_eff);
        col_next = col_wrap ? '0 : CW'(32'(c_cur) + 32'd1);
        if (!col_wrap)
            row_next = r_cur;
        else if ((32'(r_cur) + 32'd1) >= 32'(h_eff))
            row_next = '0;
        else
            row_next = RW'(32'(r_cur) + 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // A write-back in the same cycle as a read of the same column is forwarded.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= s_tdata;
            s1_col_reg   <= c_cur;
            s1_row_reg   <= r_cur;
            s1_emit_reg  <= emit_cur;
            fwd_reg      <= s1_fire && (s1_col_reg == c_cur);
            fwd_data_reg <= ram_wdata;
        end
    end

    // One word holds the column of all line buffers, oldest line in the low byte.
    assign line_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign ram_wdata = {s1_pixel_reg, line_word[LW-1:PIX_W]};

    ccw_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            if (j < LINES)
                column[j] = line_word[j*PIX_W +: PIX_W];
            else
                column[j] = s1_pixel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                for (int k = 0; k < WINDOW - 1; k++)
                begin
                    win_reg[j*WINDOW + k] <= win_reg[j*WINDOW + k + 1];
                end
                win_reg[j*WINDOW + WINDOW - 1] <= column[j];
            end
        end
    end

    // Census word for the reference position idx_reg; that position drops out.
    always_comb
    begin
        ref_px = win_reg[idx_reg];
        for (int k = 0; k < WIN_LEN; k++)
        begin
            lt[k] = (win_reg[k] < ref_px);
        end
        for (int j = 0; j < NB; j++)
        begin
            if ((NB - 1 - j) < int'(idx_reg))
                census_vec[j] = lt[NB - 1 - j];
            else
                census_vec[j] = lt[NB - j];
        end
        census_ext = CB'(census_vec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (seq_adv)
            begin
                if (seq_last)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + IW'(1);
            end
            if (s1_fire && s1_emit_reg)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            seq_col_reg <= COORD_W'(32'(s1_col_reg) - HALF);
            seq_row_reg <= COORD_W'(32'(s1_row_reg) - HALF);
        end
    end

    // Output register: a finished word waits here while the next is prepared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (seq_adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (seq_adv)
        begin
            out_col_reg    <= seq_col_reg;
            out_row_reg    <= seq_row_reg;
            out_index_reg  <= INDEX_W'(idx_reg);
            out_census_reg <= census_ext[CENSUS_W-1:0];
            out_last_reg   <= seq_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_census_reg, out_index_reg, out_row_reg, out_col_reg};

endmodule

FILE: rtl/ccw_ram.sv
`timescale 1ns / 1ps

module ccw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ccw_checker.sv
`timescale 1ns / 1ps

module ccw_checker #(
    parameter int WINDOW = ccw_pkg::DEF_WINDOW
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ccw_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    import ccw_pkg::*;

    localparam int WIN_LEN = WINDOW * WINDOW;

    // No request is offered in the cycle after reset has been applied.
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // A stalled request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The closing word of a window refers to the last window position.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[26:22] == INDEX_W'(WIN_LEN - 1))
        else $error("last word with wrong reference index");

    // Words of one window share the same centre.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || $stable(m_tdata[21:0]))
        else $error("centre changed inside a window");

endmodule

bind complete_census_window_top ccw_checker #(
    .WINDOW (WINDOW)
) u_ccw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
